>>> rtl/ske_pkg.sv
package ske_pkg;

  // Key geometry.
  localparam int unsigned Letters = 26;
  localparam int unsigned IdxW    = 5;
  localparam int unsigned ValW    = 5;
  localparam int unsigned CharW   = 8;
  localparam int unsigned FuncW   = 4;

  // Depth of the command queue between the front and back parts.
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [IdxW-1:0] LastIdx    = IdxW'(Letters - 1);
  localparam logic [IdxW-1:0] LettersIdx = IdxW'(Letters);

  // ASCII codes.
  localparam logic [CharW-1:0] CharUpperA = 8'h41;
  localparam logic [CharW-1:0] CharUpperZ = 8'h5A;
  localparam logic [CharW-1:0] CharLowerA = 8'h61;
  localparam logic [CharW-1:0] CharLowerZ = 8'h7A;
  localparam logic [CharW-1:0] CaseOffset = 8'h20;

  // Function codes on the input channel.
  localparam logic [FuncW-1:0] FuncTranslate = 4'd0;
  localparam logic [FuncW-1:0] FuncIdentity  = 4'd1;
  localparam logic [FuncW-1:0] FuncClear     = 4'd2;
  localparam logic [FuncW-1:0] FuncSwap      = 4'd3;
  localparam logic [FuncW-1:0] FuncRotLeft   = 4'd4;
  localparam logic [FuncW-1:0] FuncRotRight  = 4'd5;
  localparam logic [FuncW-1:0] FuncReverse   = 4'd6;
  localparam logic [FuncW-1:0] FuncInvert    = 4'd7;
  localparam logic [FuncW-1:0] FuncComplete  = 4'd8;
  localparam logic [FuncW-1:0] FuncWrite     = 4'd9;

  // Operations after classification by the front part.
  typedef enum logic [3:0] {
    OP_XLATE,
    OP_IDENT,
    OP_CLEAR,
    OP_SWAP,
    OP_ROTL,
    OP_ROTR,
    OP_REV,
    OP_INVERT,
    OP_COMPLETE,
    OP_WRITE,
    OP_NOP
  } op_e;

  typedef logic [ValW-1:0] entry_t;

  typedef struct packed {
    op_e              op;
    logic [CharW-1:0] ch;         // upper-cased letter, or the byte as received
    logic             is_letter;
    logic [IdxW-1:0]  addr;       // key entry read first
    logic [IdxW-1:0]  index_b;
    entry_t           value;
  } cmd_t;

  typedef struct packed {
    logic busy;   // back part is inside a swap, invert or complete key edit
    logic emit;   // a result word is loaded into the output register
  } back_status_t;

endpackage

>>> rtl/ske_in_if.sv
interface ske_in_if;
  import ske_pkg::*;

  logic             valid;
  logic             ready;
  logic [FuncW-1:0] func;
  logic [CharW-1:0] char_in;
  logic [IdxW-1:0]  index_a;
  logic [IdxW-1:0]  index_b;
  logic [ValW-1:0]  entry_value;

  modport source (
    output valid, func, char_in, index_a, index_b, entry_value,
    input  ready
  );

  modport sink (
    input  valid, func, char_in, index_a, index_b, entry_value,
    output ready
  );
endinterface

>>> rtl/ske_out_if.sv
interface ske_out_if;
  import ske_pkg::*;

  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_out;
  logic             was_mapped;

  modport source (
    output valid, char_out, was_mapped,
    input  ready
  );

  modport sink (
    input  valid, char_out, was_mapped,
    output ready
  );
endinterface

>>> rtl/substitution_key_engine.sv
// Channel  Dir  Fields                                            Word accepted when
// in_i     in   func, char_in, index_a, index_b, entry_value      in_i.valid & in_i.ready
// out_o    out  char_out, was_mapped                              out_o.valid & out_o.ready
//
// Translate and the one-step key edits (identity, clear, rotate, reverse, write)
// emit as the command is taken, so text streams at one word per cycle while the
// output is not stalled. Swap reads its two entries in turn; invert and complete
// walk the 26 key entries through the single key read port, one entry per cycle.
// Reset clears the key to all unmapped and empties the queue and output register.
// A stalled output stops the back part; the two-entry queue fills, then input stalls.
module substitution_key_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  ske_in_if.sink     in_i,
  ske_out_if.source  out_o
);
  import ske_pkg::*;

  // The front part classifies each input word into a command; the queue lets
  // the front keep accepting while the back part works through a key edit.
  logic         cmd_push;
  cmd_t         cmd_in;
  logic         fifo_ready;
  logic         cmd_valid;
  logic         cmd_ready;
  cmd_t         cmd;
  back_status_t status;

  ske_front u_front (
    .in_i         (in_i),
    .fifo_ready_i (fifo_ready),
    .push_o       (cmd_push),
    .cmd_o        (cmd_in)
  );

  ske_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .ready_o (fifo_ready),
    .valid_o (cmd_valid),
    .pop_i   (cmd_ready),
    .data_o  (cmd)
  );

  // The back part owns the key and the output register. It takes a new command
  // only between operations, and a command other than swap, invert or complete only
  // when the output register is free or being emptied in the same cycle.
  ske_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .out_o       (out_o),
    .status_o    (status)
  );

`ifndef NO_ASSERTIONS
  // The back part never pulls a command while it is in the middle of a key edit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_valid && cmd_ready && status.busy))
    else $error("command taken while a key edit is running");

  // An accepted input word is in the queue on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> cmd_valid)
    else $error("accepted word missing from the command queue");

  // A translate command produces its result in the cycle it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid && cmd_ready && (cmd.op == OP_XLATE)) |-> status.emit)
    else $error("translate command taken without a result");

  // A result loaded by the back part is offered on the output next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.emit |=> out_o.valid)
    else $error("result word lost before the output");
`endif

endmodule

>>> rtl/ske_front.sv
module ske_front (
  ske_in_if.sink         in_i,
  input  logic           fifo_ready_i,
  output logic           push_o,
  output ske_pkg::cmd_t  cmd_o
);
  import ske_pkg::*;

  logic             is_letter;
  logic [CharW-1:0] upper;

  assign in_i.ready = fifo_ready_i;
  assign push_o     = in_i.valid & fifo_ready_i;

  always_comb begin
    is_letter = ((in_i.char_in >= CharUpperA) && (in_i.char_in <= CharUpperZ)) ||
                ((in_i.char_in >= CharLowerA) && (in_i.char_in <= CharLowerZ));
    upper     = (in_i.char_in >= CharLowerA) ? (in_i.char_in - CaseOffset) : in_i.char_in;

    cmd_o.op        = OP_NOP;
    cmd_o.ch        = is_letter ? upper : in_i.char_in;
    cmd_o.is_letter = is_letter;
    cmd_o.addr      = '0;
    cmd_o.index_b   = in_i.index_b;
    cmd_o.value     = (in_i.entry_value <= ValW'(Letters)) ? in_i.entry_value : '0;

    unique case (in_i.func)
      FuncTranslate: begin
        cmd_o.op = OP_XLATE;
        if (is_letter) begin
          cmd_o.addr = IdxW'(upper - CharUpperA);
        end
      end
      FuncIdentity: cmd_o.op = OP_IDENT;
      FuncClear:    cmd_o.op = OP_CLEAR;
      FuncSwap: begin
        // A swap that names an entry beyond the key leaves the key unchanged.
        if ((in_i.index_a < LettersIdx) && (in_i.index_b < LettersIdx)) begin
          cmd_o.op   = OP_SWAP;
          cmd_o.addr = in_i.index_a;
        end
      end
      FuncRotLeft:  cmd_o.op = OP_ROTL;
      FuncRotRight: cmd_o.op = OP_ROTR;
      FuncReverse:  cmd_o.op = OP_REV;
      FuncInvert:   cmd_o.op = OP_INVERT;
      FuncComplete: cmd_o.op = OP_COMPLETE;
      FuncWrite: begin
        if (in_i.index_a < LettersIdx) begin
          cmd_o.op   = OP_WRITE;
          cmd_o.addr = in_i.index_a;
        end
      end
      default: cmd_o.op = OP_NOP;
    endcase
  end

endmodule

>>> rtl/ske_cmd_fifo.sv
module ske_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ske_pkg::cmd_t  data_i,
  output logic           ready_o,
  output logic           valid_o,
  input  logic           pop_i,
  output ske_pkg::cmd_t  data_o
);
  import ske_pkg::*;

  cmd_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0] count_q, count_d;
  logic                pop;

  assign ready_o = (count_q != FifoCntW'(FifoDepth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign pop     = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + FifoPtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + FifoPtrW'(1);
    end
    if (push_i && !pop) begin
      count_d = count_q + FifoCntW'(1);
    end else if (!push_i && pop) begin
      count_d = count_q - FifoCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/ske_back.sv
module ske_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  input  ske_pkg::cmd_t         cmd_i,
  output logic                  cmd_ready_o,
  ske_out_if.source             out_o,
  output ske_pkg::back_status_t status_o
);
  import ske_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SWAP = 3'd1;
  localparam logic [2:0] ST_INV  = 3'd2;
  localparam logic [2:0] ST_COPY = 3'd3;
  localparam logic [2:0] ST_USED = 3'd4;
  localparam logic [2:0] ST_PAIR = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  function automatic logic entry_mapped(entry_t e);
    return (e != '0) && (e <= ValW'(Letters));
  endfunction

  logic [2:0]       state_q, state_d;
  entry_t           key_q [Letters];
  entry_t           key_d [Letters];
  entry_t           tmp_q [Letters];
  entry_t           tmp_d [Letters];
  logic [Letters-1:0] used_q, used_d;
  logic [IdxW-1:0]  cnt_q, cnt_d;     // sweep index, source pointer while pairing
  logic [IdxW-1:0]  tgt_q, tgt_d;     // target pointer while pairing
  logic [IdxW-1:0]  idx_a_q, idx_a_d;
  logic [IdxW-1:0]  idx_b_q, idx_b_d;
  entry_t           hold_q, hold_d;
  logic             more_inv_q, more_inv_d;
  logic             fill_q, fill_d;

  logic             res_valid_q;
  logic [CharW-1:0] res_char_q;
  logic             res_mapped_q;
  logic             res_free;

  logic [IdxW-1:0]  rd_addr;
  entry_t           rd_data;
  logic             emit;
  logic [CharW-1:0] emit_char;
  logic             emit_mapped;

  assign res_free = !res_valid_q || out_o.ready;
  assign rd_data  = key_q[rd_addr];

  assign out_o.valid      = res_valid_q;
  assign out_o.char_out   = res_char_q;
  assign out_o.was_mapped = res_mapped_q;

  assign status_o.busy = (state_q != ST_IDLE);
  assign status_o.emit = emit;

  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    tmp_d       = tmp_q;
    used_d      = used_q;
    cnt_d       = cnt_q;
    tgt_d       = tgt_q;
    idx_a_d     = idx_a_q;
    idx_b_d     = idx_b_q;
    hold_d      = hold_q;
    more_inv_d  = more_inv_q;
    fill_d      = fill_q;
    emit        = 1'b0;
    emit_char   = '0;
    emit_mapped = 1'b0;
    cmd_ready_o = 1'b0;
    rd_addr     = cmd_i.addr;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op) inside
            OP_SWAP, OP_INVERT, OP_COMPLETE: cmd_ready_o = 1'b1;
            default:                         cmd_ready_o = res_free;
          endcase
        end
        if (cmd_valid_i && cmd_ready_o) begin
          unique case (cmd_i.op)
            OP_XLATE: begin
              emit        = 1'b1;
              emit_mapped = cmd_i.is_letter && entry_mapped(rd_data);
              emit_char   = emit_mapped ? (CharLowerA + CharW'(rd_data) - CharW'(1))
                                        : cmd_i.ch;
            end
            OP_IDENT: begin
              emit = 1'b1;
              for (int i = 0; i < Letters; i++) begin
                key_d[i] = ValW'(i + 1);
              end
            end
            OP_CLEAR: begin
              emit = 1'b1;
              for (int i = 0; i < Letters; i++) begin
                key_d[i] = '0;
              end
            end
            OP_ROTL: begin
              emit = 1'b1;
              for (int i = 0; i < Letters; i++) begin
                key_d[i] = (i == Letters - 1) ? key_q[0] : key_q[i+1];
              end
            end
            OP_ROTR: begin
              emit = 1'b1;
              for (int i = 0; i < Letters; i++) begin
                key_d[i] = (i == 0) ? key_q[Letters-1] : key_q[i-1];
              end
            end
            OP_REV: begin
              emit = 1'b1;
              for (int i = 0; i < Letters; i++) begin
                key_d[i] = key_q[Letters-1-i];
              end
            end
            OP_WRITE: begin
              emit              = 1'b1;
              key_d[cmd_i.addr] = cmd_i.value;
            end
            OP_SWAP: begin
              hold_d  = rd_data;
              idx_a_d = cmd_i.addr;
              idx_b_d = cmd_i.index_b;
              state_d = ST_SWAP;
            end
            OP_INVERT, OP_COMPLETE: begin
              for (int i = 0; i < Letters; i++) begin
                tmp_d[i] = '0;
              end
              cnt_d      = '0;
              more_inv_d = (cmd_i.op == OP_COMPLETE);
              fill_d     = (cmd_i.op == OP_COMPLETE);
              state_d    = ST_INV;
            end
            default: emit = 1'b1;
          endcase
        end
      end

      ST_SWAP: begin
        rd_addr        = idx_b_q;
        key_d[idx_a_q] = rd_data;
        key_d[idx_b_q] = hold_q;
        state_d        = ST_DONE;
      end

      ST_INV: begin
        // Later sources overwrite earlier ones on a shared target.
        rd_addr = cnt_q;
        if (entry_mapped(rd_data)) begin
          tmp_d[IdxW'(rd_data - ValW'(1))] = ValW'(cnt_q) + ValW'(1);
        end
        cnt_d = cnt_q + IdxW'(1);
        if (cnt_q == LastIdx) begin
          state_d = ST_COPY;
        end
      end

      ST_COPY: begin
        key_d = tmp_q;
        if (more_inv_q) begin
          for (int i = 0; i < Letters; i++) begin
            tmp_d[i] = '0;
          end
          cnt_d      = '0;
          more_inv_d = 1'b0;
          state_d    = ST_INV;
        end else if (fill_q) begin
          used_d  = '0;
          cnt_d   = '0;
          state_d = ST_USED;
        end else begin
          state_d = ST_DONE;
        end
      end

      ST_USED: begin
        rd_addr = cnt_q;
        if (entry_mapped(rd_data)) begin
          used_d[IdxW'(rd_data - ValW'(1))] = 1'b1;
        end
        cnt_d = cnt_q + IdxW'(1);
        if (cnt_q == LastIdx) begin
          cnt_d   = '0;
          tgt_d   = '0;
          state_d = ST_PAIR;
        end
      end

      ST_PAIR: begin
        // Walk the sources and the targets together, each in ascending order.
        if ((cnt_q == LettersIdx) || (tgt_q == LettersIdx)) begin
          state_d = ST_DONE;
        end else begin
          rd_addr = cnt_q;
          if (entry_mapped(rd_data)) begin
            cnt_d = cnt_q + IdxW'(1);
          end else if (used_q[tgt_q]) begin
            tgt_d = tgt_q + IdxW'(1);
          end else begin
            key_d[cnt_q] = ValW'(tgt_q) + ValW'(1);
            cnt_d        = cnt_q + IdxW'(1);
            tgt_d        = tgt_q + IdxW'(1);
          end
        end
      end

      ST_DONE: begin
        if (res_free) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
      for (int i = 0; i < Letters; i++) begin
        key_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      key_q   <= key_d;
      if (emit) begin
        res_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tmp_q      <= tmp_d;
    used_q     <= used_d;
    cnt_q      <= cnt_d;
    tgt_q      <= tgt_d;
    idx_a_q    <= idx_a_d;
    idx_b_q    <= idx_b_d;
    hold_q     <= hold_d;
    more_inv_q <= more_inv_d;
    fill_q     <= fill_d;
    if (emit) begin
      res_char_q   <= emit_char;
      res_mapped_q <= emit_mapped;
    end
  end

endmodule
